>>> sv/assert_macros.svh
// Assertion macros used by the top level of the sentence parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define NSP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define NSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/nsp_pkg.sv
// Types, codes and lookup functions of the NMEA sentence parser.
package nsp_pkg;

  localparam int MAX_SENTENCE_DEF = 128;
  localparam int OPQ_DEPTH        = 4;
  localparam int OUTQ_DEPTH       = 2;
  localparam int NSLOT            = 10;

  localparam logic [4:0]  NO_ERROR  = 5'd31;
  localparam logic [4:0]  FIELD_SAT = 5'd31;
  localparam logic [29:0] ACC_SAT   = 30'd999999999;
  localparam logic [29:0] ACC_LIM   = 30'd99999999;
  localparam logic [3:0]  FIX_MAX   = 4'd9;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_GGA  = 2'd1,
    KIND_RMC  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    TY_NONE, TY_TIME, TY_LAT, TY_LON, TY_NS, TY_EW,
    TY_STAT, TY_FIXQ, TY_SATS, TY_HDOP, TY_ALT, TY_DATE
  } ftype_t;

  // One operation from the front to the back: a staged write, a commit, or both.
  typedef struct packed {
    logic        wr;
    logic        commit;
    logic [3:0]  slot;
    ftype_t      ftype;
    logic        sat;
    logic [2:0]  k;
    logic        neg;
    logic [29:0] ip;
    logic [13:0] frac;
    kind_t       kind;
    logic        ok;
    logic [9:0]  mask;
  } op_t;

  typedef struct packed {
    kind_t              kind;
    logic               ok;
    logic [27:0]        utc_time;
    logic [29:0]        lat;
    logic [1:0]         lat_h;
    logic [30:0]        lon;
    logic [1:0]         lon_h;
    logic [3:0]         fix;
    logic [6:0]         sats;
    logic [13:0]        hdop;
    logic signed [20:0] alt;
    logic [18:0]        date;
  } out_rec_t;

  function automatic ftype_t field_type(kind_t k, logic [4:0] f);
    ftype_t t;
    t = TY_NONE;
    unique case (k)
      KIND_GGA: begin
        case (f)
          5'd1: t = TY_TIME;
          5'd2: t = TY_LAT;
          5'd3: t = TY_NS;
          5'd4: t = TY_LON;
          5'd5: t = TY_EW;
          5'd6: t = TY_FIXQ;
          5'd7: t = TY_SATS;
          5'd8: t = TY_HDOP;
          5'd9: t = TY_ALT;
          default: t = TY_NONE;
        endcase
      end
      KIND_RMC: begin
        case (f)
          5'd1: t = TY_TIME;
          5'd2: t = TY_STAT;
          5'd3: t = TY_LAT;
          5'd4: t = TY_NS;
          5'd5: t = TY_LON;
          5'd6: t = TY_EW;
          5'd9: t = TY_DATE;
          default: t = TY_NONE;
        endcase
      end
      default: t = TY_NONE;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] slot_of(ftype_t t);
    logic [3:0] s;
    unique case (t)
      TY_TIME: s = 4'd0;
      TY_LAT:  s = 4'd1;
      TY_NS:   s = 4'd2;
      TY_LON:  s = 4'd3;
      TY_EW:   s = 4'd4;
      TY_STAT, TY_FIXQ: s = 4'd5;
      TY_SATS: s = 4'd6;
      TY_HDOP: s = 4'd7;
      TY_ALT:  s = 4'd8;
      TY_DATE: s = 4'd9;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

>>> sv/nmea_sentence_parser.sv
// Top level of the NMEA GGA/RMC sentence parser.
// Usage:
//   Input is a character queue: drive in_char_in and raise in_push; a beat is
//   taken on a clock edge where in_push is high and in_full is low. One
//   character is taken per cycle while in_full is low.
//   Results are a queue: while out_empty is low the oldest record sits on the
//   out_ ports; raise out_pop to take it. Every newline gives one record with
//   the held position, time and fix values after that sentence's commit.
//   Each commit passes the operation queue, conversion pipeline and result queue;
//   the rate is set by the front scanner: one character a cycle while in_full is low.
//   If the receiver stalls, the two-entry result queue fills, the conversion
//   pipeline halts, the four-entry operation queue fills, and in_full rises.
//   Reset (rst_n low, synchronous) clears sentence state, held values and
//   both queues; staged values are written before they are ever committed.
`include "assert_macros.svh"
module nmea_sentence_parser #(
  parameter int MAX_SENTENCE = nsp_pkg::MAX_SENTENCE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_char_in,
  input  logic               out_pop,
  output logic               out_empty,
  output logic [1:0]         out_sentence_kind,
  output logic               out_parse_ok,
  output logic [27:0]        out_utc_time,
  output logic [29:0]        out_latitude_fixed,
  output logic [1:0]         out_lat_hemisphere,
  output logic [30:0]        out_longitude_fixed,
  output logic [1:0]         out_lon_hemisphere,
  output logic [3:0]         out_fix_status,
  output logic [6:0]         out_satellites,
  output logic [13:0]        out_hdop_centi,
  output logic signed [20:0] out_altitude_deci,
  output logic [18:0]        out_date_ddmmyy
);
  import nsp_pkg::*;

  logic     accept, op_valid, opq_empty, opq_full, op_take;
  op_t      op_new, op_head;
  out_rec_t rec;

  assign in_full = opq_full;
  assign accept  = in_push && !opq_full;

  nsp_front #(.MAX_SENTENCE(MAX_SENTENCE)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .ch       (in_char_in),
    .op_valid (op_valid),
    .op       (op_new)
  );

  nsp_fifo #(.T(op_t), .DEPTH(OPQ_DEPTH)) u_opq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (op_valid),
    .din   (op_new),
    .full  (opq_full),
    .pop   (op_take),
    .dout  (op_head),
    .empty (opq_empty)
  );

  nsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_avail  (!opq_empty),
    .op_in     (op_head),
    .op_take   (op_take),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_rec   (rec)
  );

  assign out_sentence_kind   = rec.kind;
  assign out_parse_ok        = rec.ok;
  assign out_utc_time        = rec.utc_time;
  assign out_latitude_fixed  = rec.lat;
  assign out_lat_hemisphere  = rec.lat_h;
  assign out_longitude_fixed = rec.lon;
  assign out_lon_hemisphere  = rec.lon_h;
  assign out_fix_status      = rec.fix;
  assign out_satellites      = rec.sats;
  assign out_hdop_centi      = rec.hdop;
  assign out_altitude_deci   = rec.alt;
  assign out_date_ddmmyy     = rec.date;

  `NSP_ASSERT(a_ok_needs_kind, !out_empty && out_parse_ok, out_sentence_kind != KIND_NONE, "parse_ok on unrecognized sentence")
  `NSP_ASSERT(a_fix_range, !out_empty, out_fix_status <= FIX_MAX, "fix status out of range")
  `NSP_ASSERT_NEXT(a_rec_kept, !out_empty && !out_pop, !out_empty, "waiting record lost")
endmodule

>>> sv/nsp_fifo.sv
// Small register FIFO used for the operation queue and the result queue.
module nsp_fifo #(
  parameter type T     = logic [7:0],
  parameter int  DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r, wp_nxt, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = (wp_r == AW'(DEPTH - 1)) ? '0 : AW'(wp_r + 1'b1);
    rp_nxt  = (rp_r == AW'(DEPTH - 1)) ? '0 : AW'(rp_r + 1'b1);
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = CW'(cnt_r + 1'b1);
    if (do_pop && !do_push) cnt_nxt = CW'(cnt_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_nxt;
      if (do_pop) rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= din;
  end
endmodule

>>> sv/nsp_front.sv
// Front end: sentence framing, checksum, header match and number scanning.
module nsp_front #(
  parameter int MAX_SENTENCE = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  logic [7:0]   ch,
  output logic         op_valid,
  output nsp_pkg::op_t op
);
  import nsp_pkg::*;

  logic [7:0]  count_r, count_nxt;
  logic        ins_r, ins_nxt;
  logic [4:0]  field_r, field_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic        neg_r, neg_nxt;
  logic [1:0]  hdr_r, hdr_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic        star_r, star_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [7:0]  hval_r, hval_nxt;
  logic [29:0] acc_r, acc_nxt;
  logic [29:0] int_r, int_nxt;
  logic [13:0] frac_r, frac_nxt;
  logic        sat_r, sat_nxt;
  logic [9:0]  pres_r, pres_nxt;
  logic [4:0]  err_r, err_nxt;

  kind_t      kind_cur, kind_nl;
  ftype_t     t_cur, tf;
  logic [3:0] s_cur;
  logic       first, is_num, is_letter, close_ok, ck, is_digit, is_hex, good;
  logic [3:0] dval, hexd;
  logic [1:0] code;
  logic [2:0] idx;
  logic [7:0] hchar_gga, hchar_rmc;

  always_comb begin
    kind_cur  = hdr_r[0] ? KIND_GGA : (hdr_r[1] ? KIND_RMC : KIND_NONE);
    t_cur     = field_type(kind_cur, field_r);
    s_cur     = slot_of(t_cur);
    first     = !pres_r[s_cur];
    is_letter = (t_cur == TY_NS) || (t_cur == TY_EW) || (t_cur == TY_STAT);
    is_num    = (t_cur != TY_NONE) && !is_letter;
    close_ok  = (field_r != '0) && is_num && pres_r[s_cur] && (phase_r != 3'd7);
    is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_hex    = is_digit || ((ch >= CH_A) && (ch <= CH_F));
    dval      = ch[3:0];
    hexd      = is_digit ? ch[3:0] : 4'(ch[3:0] + 4'd9);
    idx       = 3'(count_r - 8'd1);
    case (idx)
      3'd0: begin hchar_gga = CH_G; hchar_rmc = CH_G; end
      3'd1: begin hchar_gga = CH_P; hchar_rmc = CH_P; end
      3'd2: begin hchar_gga = CH_G; hchar_rmc = CH_R; end
      3'd3: begin hchar_gga = CH_G; hchar_rmc = CH_M; end
      3'd4: begin hchar_gga = CH_A; hchar_rmc = CH_C; end
      default: begin hchar_gga = 8'h00; hchar_rmc = 8'h00; end
    endcase
  end

  always_comb begin
    count_nxt = count_r; ins_nxt = ins_r; field_nxt = field_r; phase_nxt = phase_r;
    neg_nxt = neg_r; hdr_nxt = hdr_r; xor_nxt = xor_r; star_nxt = star_r;
    hcnt_nxt = hcnt_r; hval_nxt = hval_r; acc_nxt = acc_r; int_nxt = int_r;
    frac_nxt = frac_r; sat_nxt = sat_r; pres_nxt = pres_r; err_nxt = err_r;
    op_valid = 1'b0;
    ck       = 1'b0;
    good     = 1'b1;
    code     = 2'd0;
    kind_nl  = KIND_NONE;
    op.wr     = 1'b0;
    op.commit = 1'b0;
    op.slot   = s_cur;
    op.ftype  = t_cur;
    op.sat    = sat_r;
    op.k      = ((phase_r >= 3'd1) && (phase_r <= 3'd5)) ? 3'(phase_r - 3'd1) : 3'd0;
    op.neg    = neg_r;
    op.ip     = (phase_r == 3'd0) ? acc_r : int_r;
    op.frac   = frac_r;
    op.kind   = KIND_NONE;
    op.ok     = 1'b0;
    op.mask   = '0;
    if (accept) begin
      if (ch == CH_DOLLAR) begin
        ins_nxt = 1'b1; count_nxt = 8'd1; field_nxt = '0; phase_nxt = '0; neg_nxt = 1'b0;
        hdr_nxt = 2'b11; xor_nxt = '0; star_nxt = 1'b0; hcnt_nxt = '0; hval_nxt = '0;
        acc_nxt = '0; int_nxt = '0; frac_nxt = '0; sat_nxt = 1'b0;
        pres_nxt = '0; err_nxt = NO_ERROR;
      end else if (ch == CH_LF) begin
        op_valid  = 1'b1;
        op.commit = 1'b1;
        ins_nxt   = 1'b0;
        if (ins_r) begin
          ck      = !star_r || ((hcnt_r == 2'd2) && (hval_r == xor_r));
          kind_nl = kind_cur;
          if (!star_r) begin
            op.wr = close_ok;
            if ((field_r == '0) && (count_r != 8'd6)) kind_nl = KIND_NONE;
          end
          if ((kind_nl != KIND_NONE) && ck) begin
            // Commit fields that precede the first bad letter.
            for (int f = 1; f < NSLOT; f++) begin
              tf = field_type(kind_nl, 5'(f));
              if ((5'(f) < err_r) && (tf != TY_NONE) && pres_r[slot_of(tf)])
                op.mask[slot_of(tf)] = 1'b1;
            end
            op.ok = (err_r == NO_ERROR);
          end
          op.kind = kind_nl;
        end
      end else if (ins_r && (ch != CH_CR)) begin
        if (count_r >= 8'(MAX_SENTENCE)) begin
          ins_nxt = 1'b0;
        end else begin
          count_nxt = 8'(count_r + 8'd1);
          if (star_r) begin
            if ((hcnt_r < 2'd2) && is_hex) begin
              hcnt_nxt = 2'(hcnt_r + 2'd1);
              hval_nxt = {hval_r[3:0], hexd};
            end else begin
              hcnt_nxt = 2'd3;
            end
          end else if ((ch == CH_STAR) || (ch == CH_COMMA)) begin
            op_valid = close_ok;
            op.wr    = close_ok;
            if ((field_r == '0) && (count_r != 8'd6)) hdr_nxt = 2'b00;
            if (ch == CH_STAR) begin
              star_nxt = 1'b1;
            end else begin
              xor_nxt = xor_r ^ ch;
              if (field_r != FIELD_SAT) field_nxt = 5'(field_r + 5'd1);
              phase_nxt = '0; neg_nxt = 1'b0; acc_nxt = '0; int_nxt = '0;
              frac_nxt = '0; sat_nxt = 1'b0;
            end
          end else begin
            xor_nxt = xor_r ^ ch;
            if (field_r == '0) begin
              if ((count_r > 8'd5) || (ch != hchar_gga)) hdr_nxt[0] = 1'b0;
              if ((count_r > 8'd5) || (ch != hchar_rmc)) hdr_nxt[1] = 1'b0;
            end else if (t_cur != TY_NONE) begin
              pres_nxt[s_cur] = 1'b1;
              if (is_letter) begin
                if (first) begin
                  case (t_cur)
                    TY_NS: begin
                      if (ch == CH_N) code = 2'd1;
                      else if (ch == CH_S) code = 2'd2;
                      else good = 1'b0;
                    end
                    TY_EW: begin
                      if (ch == CH_E) code = 2'd1;
                      else if (ch == CH_W) code = 2'd2;
                      else good = 1'b0;
                    end
                    default: begin
                      if (ch == CH_A) code = 2'd1;
                      else if (ch == CH_V) code = 2'd0;
                      else good = 1'b0;
                    end
                  endcase
                  if (good) begin
                    op_valid = 1'b1;
                    op.wr    = 1'b1;
                    op.ip    = 30'(code);
                  end else if (err_r == NO_ERROR) begin
                    err_nxt = field_r;
                  end
                end
              end else if (phase_r != 3'd7) begin
                if (is_digit) begin
                  if (phase_r != 3'd5) begin
                    if (acc_r > ACC_LIM) begin
                      acc_nxt = ACC_SAT;
                      sat_nxt = 1'b1;
                    end else begin
                      acc_nxt = 30'((acc_r << 3) + (acc_r << 1) + 30'(dval));
                    end
                    if (phase_r != 3'd0) begin
                      phase_nxt = 3'(phase_r + 3'd1);
                      frac_nxt  = 14'((frac_r << 3) + (frac_r << 1) + 14'(dval));
                    end
                  end
                end else if ((ch == CH_DOT) && (phase_r == 3'd0)) begin
                  phase_nxt = 3'd1;
                  int_nxt   = acc_r;
                end else if ((ch == CH_MINUS) && first && (t_cur == TY_ALT)) begin
                  neg_nxt = 1'b1;
                end else begin
                  // Stop scanning: finalize what was read so far.
                  op_valid  = 1'b1;
                  op.wr     = 1'b1;
                  phase_nxt = 3'd7;
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0; ins_r <= 1'b0; field_r <= '0; phase_r <= '0; neg_r <= 1'b0;
      hdr_r <= '0; xor_r <= '0; star_r <= 1'b0; hcnt_r <= '0; hval_r <= '0;
      acc_r <= '0; int_r <= '0; frac_r <= '0; sat_r <= 1'b0;
      pres_r <= '0; err_r <= NO_ERROR;
    end else begin
      count_r <= count_nxt; ins_r <= ins_nxt; field_r <= field_nxt; phase_r <= phase_nxt;
      neg_r <= neg_nxt; hdr_r <= hdr_nxt; xor_r <= xor_nxt; star_r <= star_nxt;
      hcnt_r <= hcnt_nxt; hval_r <= hval_nxt; acc_r <= acc_nxt; int_r <= int_nxt;
      frac_r <= frac_nxt; sat_r <= sat_nxt; pres_r <= pres_nxt; err_r <= err_nxt;
    end
  end
endmodule

>>> sv/nsp_back.sv
// Back end: fixed-point conversion pipeline, staged and held values, result queue.
module nsp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              op_avail,
  input  nsp_pkg::op_t      op_in,
  output logic              op_take,
  input  logic              out_pop,
  output logic              out_empty,
  output nsp_pkg::out_rec_t out_rec
);
  import nsp_pkg::*;

  logic adv, outq_full, fire;
  op_t  a_r, b_r, c_r, d_r, e_r;
  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r;

  logic [29:0] a_ip;
  logic [13:0] a_fr;
  logic [29:0] b_ip_r, c_ip_r;
  logic [13:0] b_fr_r, c_fr_r;
  logic [60:0] c_prod_r;
  logic [30:0] c_simple_r, d_simple_r, e_simple_r;
  logic [23:0] c_q, d_q_r;
  logic [25:0] c_m50, d_m50_r;
  logic [47:0] e_qe7_r;
  logic [57:0] e_d3_r;

  logic [30:0] b_simple;
  logic [17:0] b_tcap;
  logic [16:0] b_acap;
  logic [19:0] b_altv;
  logic [16:0] b_altn;
  logic [3:0]  b_fr10_hi, b_fr1000;
  logic [9:0]  b_fr10;
  logic [6:0]  b_fr100;
  logic [6:0]  c_rem;
  logic [19:0] c_m;
  logic [47:0] e_lv;
  logic [30:0] e_val;

  logic [30:0] staged_r [NSLOT];
  logic [30:0] held_r   [NSLOT];
  logic [30:0] held_nxt [NSLOT];
  out_rec_t rec;

  assign adv     = !(e_v_r && e_r.commit && outq_full);
  assign op_take = adv;
  assign fire    = e_v_r && adv;

  // Stage A: integer and fraction parts, fraction scaled to four digits.
  always_comb begin
    if (a_r.sat) begin
      case (a_r.k)
        3'd0: begin a_ip = 30'd999999999; a_fr = 14'd0;    end
        3'd1: begin a_ip = 30'd99999999;  a_fr = 14'd9000; end
        3'd2: begin a_ip = 30'd9999999;   a_fr = 14'd9900; end
        3'd3: begin a_ip = 30'd999999;    a_fr = 14'd9990; end
        default: begin a_ip = 30'd99999;  a_fr = 14'd9999; end
      endcase
    end else begin
      a_ip = a_r.ip;
      case (a_r.k)
        3'd1: a_fr = 14'(a_r.frac * 14'd1000);
        3'd2: a_fr = 14'(a_r.frac * 14'd100);
        3'd3: a_fr = 14'(a_r.frac * 14'd10);
        3'd4: a_fr = a_r.frac;
        default: a_fr = 14'd0;
      endcase
    end
  end

  // Stage B: simple fields, and the reciprocal product for degrees.
  always_comb begin
    b_fr10_hi = 4'd0;
    b_fr10   = 10'((b_fr_r * 31'd52429) >> 19);
    b_fr100  = 7'((b_fr_r * 27'd5243) >> 19);
    b_fr1000 = 4'((b_fr_r * 28'd8389) >> 23);
    b_tcap   = (b_ip_r > 30'd235959) ? 18'd235959 : 18'(b_ip_r);
    b_acap   = (b_ip_r > 30'd100000) ? 17'd100000 : 17'(b_ip_r);
    b_altv   = 20'(b_acap * 20'd10 + 20'(b_fr1000));
    b_altn   = (b_altv > 20'd99999) ? 17'd99999 : 17'(b_altv);
    case (b_r.ftype)
      TY_TIME: b_simple = 31'(b_tcap * 28'd1000 + 28'(b_fr10));
      TY_FIXQ: b_simple = (b_ip_r > 30'd9) ? 31'd9 : 31'(b_ip_r);
      TY_SATS: b_simple = (b_ip_r > 30'd99) ? 31'd99 : 31'(b_ip_r);
      TY_DATE: b_simple = (b_ip_r > 30'd311299) ? 31'd311299 : 31'(b_ip_r);
      TY_HDOP: b_simple = (b_ip_r > 30'd99) ? 31'd9999
                          : 31'(b_ip_r * 30'd100 + 30'(b_fr100));
      TY_ALT: begin
        if (b_r.neg) b_simple = 31'(21'd0 - 21'(b_altn));
        else b_simple = (b_altv > 20'd999999) ? 31'd999999 : 31'(b_altv);
      end
      default: b_simple = 31'(b_ip_r[1:0]) | 31'(b_fr10_hi);
    endcase
  end

  // Stage C: whole degrees, and minutes in units of 1e-4 of a minute.
  always_comb begin
    c_q   = c_prod_r[60:37];
    c_rem = 7'(c_ip_r - 30'(c_q * 24'd100));
    c_m   = 20'(c_rem * 20'd10000 + 20'(c_fr_r));
    c_m50 = 26'(c_m * 26'd50);
  end

  // Final stage: combine and clamp degrees; other fields pass through.
  always_comb begin
    e_lv = e_qe7_r + 48'(e_d3_r[57:33]);
    case (e_r.ftype)
      TY_LAT:  e_val = (e_lv > 48'd999999999) ? 31'd999999999 : 31'(e_lv);
      TY_LON:  e_val = (e_lv > 48'd1899999999) ? 31'd1899999999 : 31'(e_lv);
      default: e_val = e_simple_r;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NSLOT; i++) begin
      held_nxt[i] = held_r[i];
      if (e_r.commit && e_r.mask[i]) begin
        held_nxt[i] = (e_r.wr && (e_r.slot == 4'(i))) ? e_val : staged_r[i];
      end
    end
    rec.kind     = e_r.kind;
    rec.ok       = e_r.ok;
    rec.utc_time = held_nxt[0][27:0];
    rec.lat      = held_nxt[1][29:0];
    rec.lat_h    = held_nxt[2][1:0];
    rec.lon      = held_nxt[3][30:0];
    rec.lon_h    = held_nxt[4][1:0];
    rec.fix      = held_nxt[5][3:0];
    rec.sats     = held_nxt[6][6:0];
    rec.hdop     = held_nxt[7][13:0];
    rec.alt      = held_nxt[8][20:0];
    rec.date     = held_nxt[9][18:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0; b_v_r <= 1'b0; c_v_r <= 1'b0; d_v_r <= 1'b0; e_v_r <= 1'b0;
      for (int i = 0; i < NSLOT; i++) held_r[i] <= '0;
    end else if (adv) begin
      a_v_r <= op_avail; b_v_r <= a_v_r; c_v_r <= b_v_r; d_v_r <= c_v_r; e_v_r <= d_v_r;
      if (fire && e_r.commit) begin
        for (int i = 0; i < NSLOT; i++) held_r[i] <= held_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= op_in;
      b_r <= a_r; b_ip_r <= a_ip; b_fr_r <= a_fr;
      c_r <= b_r; c_ip_r <= b_ip_r; c_fr_r <= b_fr_r; c_simple_r <= b_simple;
      c_prod_r <= 61'(b_ip_r) * 61'd1374389535;
      d_r <= c_r; d_q_r <= c_q; d_m50_r <= c_m50; d_simple_r <= c_simple_r;
      e_r <= d_r; e_simple_r <= d_simple_r;
      e_qe7_r <= 48'(d_q_r) * 48'd10000000;
      e_d3_r  <= 58'(d_m50_r) * 58'h0AAAAAAAB;
    end
    if (fire && e_r.wr) staged_r[e_r.slot] <= e_val;
  end

  nsp_fifo #(.T(out_rec_t), .DEPTH(OUTQ_DEPTH)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fire && e_r.commit),
    .din   (rec),
    .full  (outq_full),
    .pop   (out_pop),
    .dout  (out_rec),
    .empty (out_empty)
  );
endmodule
